// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Word types, operation codes, initial hash values and round constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha256_pkg;

  typedef logic [31:0] word_t;

  // Eight working words, index 0 is a, index 7 is h
  typedef word_t [0:7] work_t;

  // Operation codes
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINAL  = 1'b1;

  localparam work_t H_INIT = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Round constant table
  function automatic word_t round_k(logic [5:0] t);
    word_t k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/sha256_round.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round and one message schedule step, shared by all rounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_round import sha256_pkg::*; (
  input  work_t      cur,
  input  logic [5:0] round,
  input  word_t      w0,
  input  word_t      w1,
  input  word_t      w9,
  input  word_t      w14,
  output work_t      nxt,
  output word_t      w_new
);

  word_t t1;
  word_t t2;
  word_t sig0;
  word_t sig1;
  word_t ch;
  word_t maj;
  word_t s0;
  word_t s1;

  // Round function: w0 is the schedule word of this round
  always_comb begin
    sig1 = rotr(cur[4], 6) ^ rotr(cur[4], 11) ^ rotr(cur[4], 25);
    sig0 = rotr(cur[0], 2) ^ rotr(cur[0], 13) ^ rotr(cur[0], 22);
    ch   = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
    maj  = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);
    t1   = cur[7] + sig1 + ch + round_k(round) + w0;
    t2   = sig0 + maj;
    nxt[0] = t1 + t2;
    nxt[1] = cur[0];
    nxt[2] = cur[1];
    nxt[3] = cur[2];
    nxt[4] = cur[3] + t1;
    nxt[5] = cur[4];
    nxt[6] = cur[5];
    nxt[7] = cur[6];
  end

  // Schedule word sixteen rounds ahead
  always_comb begin
    s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    w_new = s1 + w9 + s0 + w0;
  end

endmodule

// ===== rtl/sha256_hash_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Absorbs a message one byte per transaction, pads on finalize and returns
// the 256-bit digest as eight big-endian words.
// ----------------------------------------------------------------------------
//  channel | signals                           | direction
//  --------+-----------------------------------+----------
//  in      | in_valid, in_stall, operation,    | to engine
//          | data_byte                         |
//  out     | out_valid, out_stall, digest_word,| from engine
//          | word_index, last_word             |
//
// An absorb does not stall the input, but the byte that completes a block holds
// the input off through the 64 rounds of the round unit and the chain update.
// Finalize runs one compression, or two when the length spills into a second
// block, then 8 output transactions. Output stalls hold the current word.
// Reset loads the initial hash values and clears the length count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha256_hash_engine import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_UPDATE,
    S_EMIT
  } state_t;

  localparam logic [5:0] POS_LAST   = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [3:0] LEN_WORD   = 4'd14;
  localparam logic [2:0] IDX_LAST   = 3'd7;

  state_t      state;
  work_t       chain;
  work_t       work;
  work_t       work_next;
  work_t       chain_sum;
  logic [63:0] bit_length;
  logic [5:0]  round;
  logic [2:0]  idx;
  logic        fin;
  logic        fin_extra;
  word_t       wbuf      [16];
  word_t       wbuf_next [16];
  word_t       w_new;
  logic        in_fire;
  logic [5:0]  pos;
  logic [3:0]  pw;
  logic [1:0]  lane;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign pos      = bit_length[8:3];
  assign pw       = pos[5:2];
  assign lane     = pos[1:0];

  sha256_round u_round (
    .cur   (work),
    .round (round),
    .w0    (wbuf[0]),
    .w1    (wbuf[1]),
    .w9    (wbuf[9]),
    .w14   (wbuf[14]),
    .nxt   (work_next),
    .w_new (w_new)
  );

  // Chain update after the last round
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain_sum[i] = chain[i] + work[i];
    end
  end

  // Block buffer: byte writes, padding, schedule shift
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      wbuf_next[i] = wbuf[i];
    end
    if (in_fire && operation == OP_ABSORB) begin
      for (int b = 0; b < 4; b++) begin
        if (b == int'(lane)) begin
          wbuf_next[pw][31 - 8 * b -: 8] = data_byte;
        end
      end
    end else if (in_fire) begin
      // 0x80 marker, zero tail, length if it fits in this block
      for (int i = 0; i < 16; i++) begin
        if (i == int'(pw)) begin
          for (int b = 0; b < 4; b++) begin
            if (b == int'(lane)) begin
              wbuf_next[i][31 - 8 * b -: 8] = 8'h80;
            end else if (b > int'(lane)) begin
              wbuf_next[i][31 - 8 * b -: 8] = 8'h00;
            end
          end
        end else if (i > int'(pw)) begin
          wbuf_next[i] = '0;
        end
      end
      if (pw < LEN_WORD) begin
        wbuf_next[14] = bit_length[63:32];
        wbuf_next[15] = bit_length[31:0];
      end
    end else if (state == S_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        wbuf_next[i] = wbuf[i + 1];
      end
      wbuf_next[15] = w_new;
    end else if (state == S_UPDATE && fin && fin_extra) begin
      for (int i = 0; i < 14; i++) begin
        wbuf_next[i] = '0;
      end
      wbuf_next[14] = bit_length[63:32];
      wbuf_next[15] = bit_length[31:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      wbuf[i] <= wbuf_next[i];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      chain      <= H_INIT;
      bit_length <= '0;
      round      <= '0;
      idx        <= '0;
      fin        <= 1'b0;
      fin_extra  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (operation == OP_ABSORB) begin
              bit_length <= bit_length + 64'd8;
              if (pos == POS_LAST) begin
                work  <= chain;
                round <= '0;
                fin   <= 1'b0;
                state <= S_ROUND;
              end
            end else begin
              fin       <= 1'b1;
              fin_extra <= (pw >= LEN_WORD);
              work      <= chain;
              round     <= '0;
              state     <= S_ROUND;
            end
          end
        end
        S_ROUND: begin
          work  <= work_next;
          round <= round + 6'd1;
          if (round == ROUND_LAST) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          chain <= chain_sum;
          if (fin && fin_extra) begin
            fin_extra <= 1'b0;
            work      <= chain_sum;
            round     <= '0;
            state     <= S_ROUND;
          end else if (fin) begin
            out_valid <= 1'b1;
            idx       <= '0;
            state     <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (idx == IDX_LAST) begin
              out_valid  <= 1'b0;
              chain      <= H_INIT;
              bit_length <= '0;
              fin        <= 1'b0;
              state      <= S_IDLE;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Digest words straight from the chain registers
  assign digest_word = chain[idx];
  assign word_index  = idx;
  assign last_word   = (idx == IDX_LAST);

  // Checks
  `ASSERT_CLK(a_out_blocks_in, !out_valid || in_stall, "output pending while input open")
  `ASSERT_NEXT(a_round_end, state == S_ROUND && round == ROUND_LAST,
    state == S_UPDATE, "round count did not end compression")
  `ASSERT_NEXT(a_last_restart, out_valid && !out_stall && last_word,
    !out_valid && bit_length == 64'd0 && chain == H_INIT, "no restart after digest")
  `ASSERT_NEXT(a_word_step, out_valid && !out_stall && !last_word,
    out_valid && word_index == $past(word_index) + 3'd1, "digest word skipped")

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hash engine testbench
// Streams messages into the engine one byte per transaction, finalizes them,
// and checks every digest word against a behavioral SHA-256 kept in a small
// scoreboard class. Both channels idle at random, and the sender sometimes
// waits for the digest to drain before it goes on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import sha256_pkg::*; ();

  // Scoreboard: behavioral hash plus the queue of digest words still owed
  class digest_book;
    typedef struct packed {
      word_t      value;
      logic [2:0] position;
      logic       is_last;
    } digest_item_t;

    word_t        chain[8];
    logic [7:0]   blk[64];
    logic [63:0]  bit_len;
    word_t        k_tab[64];
    digest_item_t pending_q[$];
    int           fail_cnt;

    function new();
      k_tab = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
      };
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      fail_cnt = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = H_INIT[i];
      bit_len = '0;
    endfunction

    function word_t ror(word_t x, int n);
      logic [63:0] dbl;
      dbl = {x, x} >> n;
      return dbl[31:0];
    endfunction

    // One 64-round compression of the block buffer into the chain
    function void compress();
      word_t w[64];
      word_t v[8];
      word_t s0, s1, t1, t2;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[i] + w[i];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        for (int j = 7; j > 0; j--) v[j] = v[j-1];
        v[4] = v[4] + t1;
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    // Accepted input transaction: absorb a byte or pad and queue the digest
    function void note_input(logic op, logic [7:0] b);
      int pos;
      digest_item_t item;
      pos = int'(bit_len[8:3]);
      if (op == OP_ABSORB) begin
        blk[pos] = b;
        bit_len  = bit_len + 64'd8;
        if (pos == 63) compress();
        return;
      end
      blk[pos] = 8'h80;
      pos++;
      if (pos <= 56) begin
        for (int i = pos; i < 56; i++) blk[i] = 8'h00;
      end else begin
        // length does not fit: close this block and pad a second one
        for (int i = pos; i < 64; i++) blk[i] = 8'h00;
        compress();
        for (int i = 0; i < 56; i++) blk[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        item.value    = chain[i];
        item.position = 3'(i);
        item.is_last  = (i == 7);
        pending_q.push_back(item);
      end
      restart();
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      fail_cnt++;
    endtask

    // Accepted output transaction against the oldest owed digest word
    task check_result(word_t w, logic [2:0] idx, logic last);
      digest_item_t exp_item;
      if (pending_q.size() == 0) begin
        report($sformatf("digest word %h with nothing pending", w));
        return;
      end
      exp_item = pending_q.pop_front();
      if (w !== exp_item.value)
        report($sformatf("digest_word %h, want %h", w, exp_item.value));
      if (idx !== exp_item.position)
        report($sformatf("word_index %0d, want %0d", idx, exp_item.position));
      if (last !== exp_item.is_last)
        report($sformatf("last_word %b, want %b", last, exp_item.is_last));
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic        operation  = OP_ABSORB;
  logic [7:0]  data_byte  = 8'h00;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  bit          steady     = 1'b0;
  digest_book  book;

  sha256_hash_engine dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  always #4 clk = ~clk;

  // Receiver backpressure, off while a steady stretch runs
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 22);
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      book.check_result(digest_word, word_index, last_word);
  end

  // One input transaction, with an optional random gap in front of it
  task automatic send_item(logic op, logic [7:0] b);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 22) begin
      in_valid  <= 1'b0;
      operation <= 1'($urandom_range(1));
      data_byte <= 8'($urandom_range(255));
      do @(negedge clk); while ($urandom_range(99) < 22);
    end
    in_valid  <= 1'b1;
    operation <= op;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_input(op, b);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom_range(255)));
    send_item(OP_FINAL, 8'($urandom_range(255)));
  endtask

  // Hold the sender off until every owed digest word has come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    book = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty messages, with data bytes that must be ignored
    send_item(OP_FINAL, 8'hff);
    send_item(OP_FINAL, 8'h00);
    // "abc"
    send_item(OP_ABSORB, 8'h61);
    send_item(OP_ABSORB, 8'h62);
    send_item(OP_ABSORB, 8'h63);
    send_item(OP_FINAL, 8'h5a);
    // single-byte messages at the byte extremes
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_FINAL, 8'h00);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_FINAL, 8'hff);
    // alternating and single-bit patterns
    send_item(OP_ABSORB, 8'h55);
    send_item(OP_ABSORB, 8'haa);
    send_item(OP_ABSORB, 8'h01);
    send_item(OP_ABSORB, 8'h80);
    send_item(OP_FINAL, 8'h7f);
    drain();

    // Padding boundary: length spills into a second block
    send_message(56);
    // Exactly one full block, no idling on either side
    steady = 1'b1;
    send_message(64);
    drain();
    steady = 1'b0;

    // Random short messages
    for (int m = 0; m < 4; m++) begin
      len = $urandom_range(6);
      send_message(len);
      if (m == 1) drain();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending_q.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    if (book.fail_cnt == 0 && book.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
